// ===== rtl/psv_pkg.sv =====
package psv_pkg;

  localparam int GRID_BITS      = 12;
  localparam int MAX_VARS       = 4;
  localparam int MAX_CANDIDATES = 64;

  localparam int DIM_W   = GRID_BITS + 1;
  localparam int IDX_W   = GRID_BITS;
  localparam int COORD_W = 20;
  localparam int VAL_W   = 32;
  localparam int WGT_W   = 16;

  // shared divider and square root widths
  localparam int DIV_N_W = 64;
  localparam int DIV_D_W = 48;
  localparam int SQ_W    = 48;
  localparam int ROOT_W  = 25;

  localparam logic [DIM_W-1:0] GRID_MAX = DIM_W'(1 << GRID_BITS);

  // result kinds
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_DEFER  = 2'd1;
  localparam logic [1:0] KIND_OVER   = 2'd2;

  // register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_W   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_H   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_D   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VCOL_MIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VCOL_MAX = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VROW_MIN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VROW_MAX = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DEFER    = 3'd7;

  typedef struct packed {
    logic signed [COORD_W-1:0] box_x_lo;
    logic signed [COORD_W-1:0] box_x_hi;
    logic signed [COORD_W-1:0] box_y_lo;
    logic signed [COORD_W-1:0] box_y_hi;
    logic signed [COORD_W-1:0] box_z_lo;
    logic signed [COORD_W-1:0] box_z_hi;
    logic [2:0]                var_count;
    logic signed [VAL_W-1:0]   var_a;
    logic signed [VAL_W-1:0]   var_b;
    logic signed [VAL_W-1:0]   var_c;
    logic signed [VAL_W-1:0]   var_d;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              item_kind;
    logic [IDX_W-1:0]        col;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col_end;
    logic [IDX_W-1:0]        row_end;
    logic [IDX_W-1:0]        slice;
    logic [WGT_W-1:0]        weight;
    logic signed [VAL_W-1:0] wvar_a;
    logic signed [VAL_W-1:0] wvar_b;
    logic signed [VAL_W-1:0] wvar_c;
    logic signed [VAL_W-1:0] wvar_d;
    logic                    last;
  } out_item_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic            start;
    logic [SQ_W-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

  // grid size as used: zero counts as one, clamp to the grid limit
  function automatic logic [DIM_W-1:0] grid_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) r = DIM_W'(1);
    else if (v > GRID_MAX) r = GRID_MAX;
    else r = v;
    return r;
  endfunction

endpackage

// ===== rtl/psv_div.sv =====
module psv_div
  import psv_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIV_N_W + 1);

  logic [DIV_N_W-1:0] dvd_r;
  logic [DIV_N_W-1:0] quo_r;
  logic [DIV_D_W-1:0] dsr_r;
  logic [DIV_D_W-1:0] rem_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;

  logic [DIV_D_W:0] rem_sh;
  logic [DIV_D_W:0] diff;
  logic             ge;

  // one quotient bit per cycle, restoring
  assign rem_sh = {rem_r, dvd_r[DIV_N_W-1]};
  assign diff   = rem_sh - {1'b0, dsr_r};
  assign ge     = (rem_sh >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_N_W);
        dvd_r  <= req.dividend;
        dsr_r  <= req.divisor;
        rem_r  <= '0;
        quo_r  <= '0;
      end else if (busy_r) begin
        rem_r <= ge ? diff[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
        quo_r <= {quo_r[DIV_N_W-2:0], ge};
        dvd_r <= {dvd_r[DIV_N_W-2:0], 1'b0};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

// ===== rtl/psv_sqrt.sv =====
module psv_sqrt
  import psv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  sqrt_req_t req,
  output sqrt_rsp_t rsp
);

  logic [SQ_W-1:0]   x_r;
  logic [SQ_W-1:0]   r_r;
  logic [SQ_W-1:0]   bit_r;
  logic [ROOT_W-1:0] root_r;
  logic              busy_r;
  logic              done_r;

  logic [SQ_W-1:0] t;
  logic [SQ_W-1:0] x_nxt;
  logic [SQ_W-1:0] r_nxt;

  // two radicand bits per cycle
  always_comb begin
    t = r_r + bit_r;
    if (x_r >= t) begin
      x_nxt = x_r - t;
      r_nxt = (r_r >> 1) + bit_r;
    end else begin
      x_nxt = x_r;
      r_nxt = r_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        x_r    <= req.radicand;
        r_r    <= '0;
        bit_r  <= SQ_W'(1) << (SQ_W - 2);
      end else if (busy_r) begin
        x_r   <= x_nxt;
        r_r   <= r_nxt;
        bit_r <= bit_r >> 2;
        if (bit_r == SQ_W'(1)) begin
          // round up when a remainder is left
          busy_r <= 1'b0;
          done_r <= 1'b1;
          root_r <= ROOT_W'(r_nxt) + ROOT_W'(x_nxt != '0);
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.root = root_r;

endmodule

// ===== rtl/point_splat_volume_sampler.sv =====
// point splat volume sampler
// input channel (in_valid / in_ready / in_data): one point per request, a
//   bounding box and up to four values; in_ready is high only while the
//   sequencer is idle, so one point is worked on at a time
// result channel (out_valid / out_ready / out_data): weighted samples in
//   column, row, slice order, last set on the final one; an oversized window
//   gives a single deferred or overflow request instead
// configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data):
//   always ready, write only while no point is in flight
// datapath: all arithmetic goes through one multiplier, one 64-step divider
//   and one 24-step square root; the divider sets the pace
//   setup finds the three minimum half-extents with the divider, each new
//   column or row in the grid takes a division, each window candidate a
//   division and distance multiplies, and each sample inside the radius
//   a weight division, multiplies and a push
// output: a one-deep output register plus a holding register; the
//   sequencer stalls only when both are full and out_ready is low
// reset: synchronous, active low; restores the registers to their defaults,
//   drops any point in flight and empties the output
module point_splat_volume_sampler
  import psv_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  // sequencer states
  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_MH    = 5'd1;
  localparam logic [4:0] ST_SQ    = 5'd2;
  localparam logic [4:0] ST_SQRT  = 5'd3;
  localparam logic [4:0] ST_WIN   = 5'd4;
  localparam logic [4:0] ST_CLIP  = 5'd5;
  localparam logic [4:0] ST_CNT   = 5'd6;
  localparam logic [4:0] ST_OVER  = 5'd7;
  localparam logic [4:0] ST_XPOS  = 5'd8;
  localparam logic [4:0] ST_YPOS  = 5'd9;
  localparam logic [4:0] ST_ZPOS  = 5'd10;
  localparam logic [4:0] ST_DIST  = 5'd11;
  localparam logic [4:0] ST_QDIV  = 5'd12;
  localparam logic [4:0] ST_WGT   = 5'd13;
  localparam logic [4:0] ST_VAL   = 5'd14;
  localparam logic [4:0] ST_PUSH  = 5'd15;
  localparam logic [4:0] ST_NEXTK = 5'd16;
  localparam logic [4:0] ST_NEXTJ = 5'd17;
  localparam logic [4:0] ST_NEXTI = 5'd18;
  localparam logic [4:0] ST_FIN   = 5'd19;

  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 25;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int TERM_W  = 27;
  localparam int DIST_W  = 23;
  localparam int ACC_W   = 48;
  localparam int HALF_W  = 21;
  localparam int CW      = COORD_W;

  // 1.5 grid spacings of the full [-1,1] span, in 2^-17 units times n
  localparam int MH_NUM = 196608;
  localparam logic signed [TERM_W-1:0] ONE18 = TERM_W'(1 << 18);
  localparam logic signed [DIST_W-1:0] ONE17 = DIST_W'(1 << 17);
  localparam logic signed [PROD_W-1:0] CEIL19 = PROD_W'((1 << 19) - 1);
  localparam logic [WGT_W-1:0] WGT_SAT = '1;

  // configuration
  logic [DIM_W-1:0] gw_r, gh_r, gd_r;
  logic [IDX_W-1:0] vcmin_r, vcmax_r, vrmin_r, vrmax_r;
  logic             defer_r;

  logic [4:0] state_r;
  logic       ph_r;
  logic [2:0] step_r;

  in_item_t in_r;

  logic signed [HALF_W-1:0] d_r [3];
  logic [ACC_W-1:0]         acc_r;
  logic [SQ_W-1:0]          r2_r;
  logic [ROOT_W-1:0]        r18_r;
  logic signed [CW-1:0]     win_r [6];
  logic [12:0]              cnt_r;
  logic signed [CW-1:0]     i_r, j_r, k_r;
  logic signed [DIST_W-1:0] xd_r, yd_r, zd_r;
  logic [ACC_W-1:0]         rd_r;
  logic [16:0]              q_r;
  logic [WGT_W-1:0]         w_r;
  logic signed [VAL_W-1:0]  wv_r [4];

  logic signed [PROD_W-1:0] prod_r;

  out_item_t out_r;
  logic      out_valid_r;
  out_item_t hold_r;
  logic      hold_v_r;

  // working values
  logic [DIM_W-1:0] dim_w, dim_h, dim_d;
  logic signed [CW-1:0] wdim_s, hdim_s, ddim_s;
  logic signed [HALF_W-1:0] cx, cy, cz;
  logic signed [TERM_W-1:0] cx2, cy2, cz4, r18e, term;
  logic [DIM_W-1:0] dim_sel;
  logic [DIM_W-1:0] mh_dim;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic [2:0] nv;
  logic out_free;
  logic out_load;
  logic x_in, y_in, z_in;

  logic signed [CW-1:0] vcmin_s, vcmax_s, vrmin_s, vrmax_s;
  logic signed [CW-1:0] cminx, cmaxx, cminy, cmaxy;
  logic out_of_view, empty_win;
  logic signed [CW:0] spx, spy, spz;
  logic too_wide;

  logic signed [HALF_W-1:0] ext_sel, mh_sel, half_sel;
  logic [ACC_W-1:0] acc_sum, d4;
  logic signed [PROD_W-1:0] win_sh;
  logic signed [HALF_W:0] xq, zq;
  logic [16:0] wq;
  out_item_t new_item, over_item, fin_item;

  div_req_t  div_req;
  div_rsp_t  div_rsp;
  sqrt_req_t sq_req;
  sqrt_rsp_t sq_rsp;

  psv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  psv_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sq_req),
    .rsp   (sq_rsp)
  );

  assign dim_w  = grid_dim(gw_r);
  assign dim_h  = grid_dim(gh_r);
  assign dim_d  = grid_dim(gd_r);
  assign wdim_s = CW'(dim_w);
  assign hdim_s = CW'(dim_h);
  assign ddim_s = CW'(dim_d);

  // box centers in 2^-17 units
  assign cx = HALF_W'(in_r.box_x_lo) + HALF_W'(in_r.box_x_hi);
  assign cy = HALF_W'(in_r.box_y_lo) + HALF_W'(in_r.box_y_hi);
  assign cz = HALF_W'(in_r.box_z_lo) + HALF_W'(in_r.box_z_hi);
  assign cx2  = TERM_W'(cx) <<< 1;
  assign cy2  = TERM_W'(cy) <<< 1;
  assign cz4  = TERM_W'(cz) <<< 2;
  assign r18e = TERM_W'(r18_r);

  assign nv = (in_r.var_count > 3'(MAX_VARS)) ? 3'(MAX_VARS) : in_r.var_count;
  assign out_free = !out_valid_r || out_ready;
  assign out_load = out_free && ((state_r == ST_OVER) ||
                    (hold_v_r && ((state_r == ST_PUSH) || (state_r == ST_FIN))));

  assign x_in = (i_r < wdim_s);
  assign y_in = (j_r < hdim_s);
  assign z_in = !k_r[CW-1] && (k_r < ddim_s);

  // grid size of the axis whose minimum half-extent is being found
  assign mh_dim = (step_r[1:0] == 2'd0) ? dim_w :
                  (step_r[1:0] == 2'd1) ? dim_h : dim_d;

  // window edge terms, even steps round up, odd steps round down
  always_comb begin
    unique case (step_r)
      3'd0:    begin term = cx2 - r18e + ONE18; dim_sel = dim_w; end
      3'd1:    begin term = cx2 + r18e + ONE18; dim_sel = dim_w; end
      3'd2:    begin term = cy2 - r18e + ONE18; dim_sel = dim_h; end
      3'd3:    begin term = cy2 + r18e + ONE18; dim_sel = dim_h; end
      3'd4:    begin term = cz4 - r18e;         dim_sel = dim_d; end
      default: begin term = cz4 + r18e;         dim_sel = dim_d; end
    endcase
  end

  assign win_sh = step_r[0] ? (prod_r >>> 19) : ((prod_r + CEIL19) >>> 19);

  // view clip
  assign vcmin_s = CW'(vcmin_r);
  assign vcmax_s = CW'(vcmax_r);
  assign vrmin_s = CW'(vrmin_r);
  assign vrmax_s = CW'(vrmax_r);
  assign out_of_view = (win_r[0] > vcmax_s) || (win_r[1] < vcmin_s) ||
                       (win_r[2] > vrmax_s) || (win_r[3] < vrmin_s);
  assign cminx = (win_r[0] < vcmin_s) ? vcmin_s : win_r[0];
  assign cmaxx = (win_r[1] > vcmax_s) ? vcmax_s : win_r[1];
  assign cminy = (win_r[2] < vrmin_s) ? vrmin_s : win_r[2];
  assign cmaxy = (win_r[3] > vrmax_s) ? vrmax_s : win_r[3];
  assign empty_win = (cmaxx < cminx) || (cmaxy < cminy) || (win_r[5] < win_r[4]);

  // spans of the stored window, clipped once the clip state has run
  assign spx = (CW+1)'(win_r[1]) - (CW+1)'(win_r[0]) + (CW+1)'(1);
  assign spy = (CW+1)'(win_r[3]) - (CW+1)'(win_r[2]) + (CW+1)'(1);
  assign spz = (CW+1)'(win_r[5]) - (CW+1)'(win_r[4]) + (CW+1)'(1);
  assign too_wide = (spx > (CW+1)'(MAX_CANDIDATES)) || (spy > (CW+1)'(MAX_CANDIDATES)) ||
                    (spz > (CW+1)'(MAX_CANDIDATES));

  // half-extent of the current axis, raised to its minimum
  always_comb begin
    unique case (step_r[1:0])
      2'd0:    ext_sel = HALF_W'(in_r.box_x_hi) - HALF_W'(in_r.box_x_lo);
      2'd1:    ext_sel = HALF_W'(in_r.box_y_hi) - HALF_W'(in_r.box_y_lo);
      default: ext_sel = HALF_W'(in_r.box_z_hi) - HALF_W'(in_r.box_z_lo);
    endcase
    if (step_r[1:0] == 2'd2 && dim_d == DIM_W'(1)) mh_sel = '0;
    else mh_sel = HALF_W'(div_rsp.quot[17:0]);
    half_sel = (ext_sel < mh_sel) ? mh_sel : ext_sel;
  end

  assign acc_sum = acc_r + ACC_W'(prod_r);
  assign d4      = {acc_sum[ACC_W-3:0], 2'b00};

  assign xq = (HALF_W+1)'(div_rsp.quot[19:0]);
  assign zq = (HALF_W+1)'(div_rsp.quot[19:0]) - (HALF_W+1)'(cz);
  assign wq = prod_r[32:16];

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_SQ: begin
        mul_a = MUL_A_W'(d_r[step_r[1:0]]);
        mul_b = MUL_B_W'(d_r[step_r[1:0]]);
      end
      ST_WIN: begin
        mul_a = MUL_A_W'(term);
        mul_b = MUL_B_W'(dim_sel);
      end
      ST_CNT: begin
        if (step_r[0]) begin
          mul_a = MUL_A_W'(cnt_r);
          mul_b = MUL_B_W'(spz[6:0]);
        end else begin
          mul_a = MUL_A_W'(spx[6:0]);
          mul_b = MUL_B_W'(spy[6:0]);
        end
      end
      ST_DIST: begin
        unique case (step_r[1:0])
          2'd0:    begin mul_a = MUL_A_W'(xd_r); mul_b = MUL_B_W'(xd_r); end
          2'd1:    begin mul_a = MUL_A_W'(yd_r); mul_b = MUL_B_W'(yd_r); end
          default: begin mul_a = MUL_A_W'(zd_r); mul_b = MUL_B_W'(zd_r); end
        endcase
      end
      ST_WGT: begin
        mul_a = MUL_A_W'(q_r);
        mul_b = MUL_B_W'(q_r);
      end
      ST_VAL: begin
        unique case (step_r[1:0])
          2'd0:    mul_a = MUL_A_W'(in_r.var_a);
          2'd1:    mul_a = MUL_A_W'(in_r.var_b);
          2'd2:    mul_a = MUL_A_W'(in_r.var_c);
          default: mul_a = MUL_A_W'(in_r.var_d);
        endcase
        mul_b = MUL_B_W'(w_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // divider and square root requests
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    unique case (state_r)
      ST_MH: begin
        div_req.start    = !ph_r;
        div_req.dividend = DIV_N_W'(MH_NUM) + DIV_N_W'(mh_dim) - DIV_N_W'(1);
        div_req.divisor  = DIV_D_W'(mh_dim);
      end
      ST_XPOS: begin
        div_req.start    = !ph_r && x_in;
        div_req.dividend = DIV_N_W'({i_r[IDX_W-1:0], 18'b0}) + DIV_N_W'(dim_w >> 1);
        div_req.divisor  = DIV_D_W'(dim_w);
      end
      ST_YPOS: begin
        div_req.start    = !ph_r && y_in;
        div_req.dividend = DIV_N_W'({j_r[IDX_W-1:0], 18'b0}) + DIV_N_W'(dim_h >> 1);
        div_req.divisor  = DIV_D_W'(dim_h);
      end
      ST_ZPOS: begin
        div_req.start    = !ph_r && z_in;
        div_req.dividend = DIV_N_W'({k_r[IDX_W-1:0], 17'b0}) + DIV_N_W'(dim_d >> 1);
        div_req.divisor  = DIV_D_W'(dim_d);
      end
      ST_QDIV: begin
        div_req.start    = !ph_r;
        div_req.dividend = {rd_r, 16'b0};
        div_req.divisor  = DIV_D_W'(r2_r);
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  assign sq_req.start    = (state_r == ST_SQRT) && !ph_r;
  assign sq_req.radicand = r2_r;

  // result requests
  always_comb begin
    new_item           = '0;
    new_item.item_kind = KIND_SAMPLE;
    new_item.col       = i_r[IDX_W-1:0];
    new_item.row       = j_r[IDX_W-1:0];
    new_item.slice     = k_r[IDX_W-1:0];
    new_item.weight    = w_r;
    new_item.wvar_a    = wv_r[0];
    new_item.wvar_b    = wv_r[1];
    new_item.wvar_c    = wv_r[2];
    new_item.wvar_d    = wv_r[3];
    over_item           = '0;
    over_item.item_kind = defer_r ? KIND_DEFER : KIND_OVER;
    over_item.col       = win_r[0][IDX_W-1:0];
    over_item.row       = win_r[2][IDX_W-1:0];
    over_item.col_end   = win_r[1][IDX_W-1:0];
    over_item.row_end   = win_r[3][IDX_W-1:0];
    over_item.last      = 1'b1;
    fin_item            = hold_r;
    fin_item.last       = 1'b1;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r    <= DIM_W'(256);
      gh_r    <= DIM_W'(256);
      gd_r    <= DIM_W'(256);
      vcmin_r <= '0;
      vcmax_r <= IDX_W'(255);
      vrmin_r <= '0;
      vrmax_r <= IDX_W'(255);
      defer_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GRID_W:   gw_r    <= cfg_data;
        REG_GRID_H:   gh_r    <= cfg_data;
        REG_GRID_D:   gd_r    <= cfg_data;
        REG_VCOL_MIN: vcmin_r <= cfg_data[IDX_W-1:0];
        REG_VCOL_MAX: vcmax_r <= cfg_data[IDX_W-1:0];
        REG_VROW_MIN: vrmin_r <= cfg_data[IDX_W-1:0];
        REG_VROW_MAX: vrmax_r <= cfg_data[IDX_W-1:0];
        REG_DEFER:    defer_r <= cfg_data[0];
        default:      defer_r <= defer_r;
      endcase
    end
  end

  // output valid: set on a load, cleared once the request is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ph_r        <= 1'b0;
      step_r      <= '0;
      hold_v_r    <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            in_r    <= in_data;
            state_r <= ST_MH;
            ph_r    <= 1'b0;
            step_r  <= '0;
          end
        end

        // minimum half-extent per axis
        ST_MH: begin
          if (!ph_r) ph_r <= 1'b1;
          else if (div_rsp.done) begin
            d_r[step_r[1:0]] <= half_sel;
            ph_r <= 1'b0;
            if (step_r == 3'd2) begin
              step_r  <= '0;
              acc_r   <= '0;
              state_r <= ST_SQ;
            end else begin
              step_r <= step_r + 3'd1;
            end
          end
        end

        // sum of squared half-extents, then radius squared times 9
        ST_SQ: begin
          if (!ph_r) ph_r <= 1'b1;
          else begin
            ph_r  <= 1'b0;
            acc_r <= acc_sum;
            if (step_r == 3'd2) begin
              r2_r    <= (acc_sum << 3) + acc_sum;
              state_r <= ST_SQRT;
            end else begin
              step_r <= step_r + 3'd1;
            end
          end
        end

        ST_SQRT: begin
          if (!ph_r) ph_r <= 1'b1;
          else if (sq_rsp.done) begin
            r18_r   <= sq_rsp.root;
            ph_r    <= 1'b0;
            step_r  <= '0;
            state_r <= ST_WIN;
          end
        end

        // window edges, scaled by grid size
        ST_WIN: begin
          if (!ph_r) ph_r <= 1'b1;
          else begin
            ph_r <= 1'b0;
            win_r[step_r] <= win_sh[CW-1:0];
            if (step_r == 3'd5) state_r <= ST_CLIP;
            else step_r <= step_r + 3'd1;
          end
        end

        ST_CLIP: begin
          step_r <= '0;
          if (out_of_view || empty_win) begin
            state_r <= ST_IDLE;
          end else begin
            win_r[0] <= cminx;
            win_r[1] <= cmaxx;
            win_r[2] <= cminy;
            win_r[3] <= cmaxy;
            state_r  <= ST_CNT;
          end
        end

        // candidate count; any span or a candidate count above the limit means oversized
        ST_CNT: begin
          if (too_wide) begin
            state_r <= ST_OVER;
          end else if (!ph_r) begin
            ph_r <= 1'b1;
          end else begin
            ph_r <= 1'b0;
            if (!step_r[0]) begin
              cnt_r  <= prod_r[12:0];
              step_r <= 3'd1;
            end else if (prod_r > PROD_W'(MAX_CANDIDATES)) begin
              state_r <= ST_OVER;
            end else begin
              i_r     <= win_r[0];
              state_r <= ST_XPOS;
            end
          end
        end

        ST_OVER: begin
          if (out_free) begin
            out_r   <= over_item;
            state_r <= ST_IDLE;
          end
        end

        ST_XPOS: begin
          if (!ph_r) begin
            if (x_in) ph_r <= 1'b1;
            else state_r <= ST_NEXTI;
          end else if (div_rsp.done) begin
            ph_r    <= 1'b0;
            xd_r    <= DIST_W'(xq) - ONE17 - DIST_W'(cx);
            j_r     <= win_r[2];
            state_r <= ST_YPOS;
          end
        end

        ST_YPOS: begin
          if (!ph_r) begin
            if (y_in) ph_r <= 1'b1;
            else state_r <= ST_NEXTJ;
          end else if (div_rsp.done) begin
            ph_r    <= 1'b0;
            yd_r    <= DIST_W'(xq) - ONE17 - DIST_W'(cy);
            k_r     <= win_r[4];
            state_r <= ST_ZPOS;
          end
        end

        // z distance counts twice
        ST_ZPOS: begin
          if (!ph_r) begin
            if (z_in) ph_r <= 1'b1;
            else state_r <= ST_NEXTK;
          end else if (div_rsp.done) begin
            ph_r    <= 1'b0;
            zd_r    <= DIST_W'(zq) <<< 1;
            step_r  <= '0;
            acc_r   <= '0;
            state_r <= ST_DIST;
          end
        end

        ST_DIST: begin
          if (!ph_r) ph_r <= 1'b1;
          else begin
            ph_r  <= 1'b0;
            acc_r <= acc_sum;
            if (step_r == 3'd2) begin
              if (d4 >= r2_r) begin
                state_r <= ST_NEXTK;
              end else begin
                rd_r    <= r2_r - d4;
                state_r <= ST_QDIV;
              end
            end else begin
              step_r <= step_r + 3'd1;
            end
          end
        end

        ST_QDIV: begin
          if (!ph_r) ph_r <= 1'b1;
          else if (div_rsp.done) begin
            ph_r    <= 1'b0;
            q_r     <= div_rsp.quot[16:0];
            state_r <= ST_WGT;
          end
        end

        ST_WGT: begin
          if (!ph_r) ph_r <= 1'b1;
          else begin
            ph_r    <= 1'b0;
            w_r     <= wq[16] ? WGT_SAT : wq[WGT_W-1:0];
            step_r  <= '0;
            state_r <= ST_VAL;
          end
        end

        // weighted values, unused lanes read zero
        ST_VAL: begin
          if (!ph_r) ph_r <= 1'b1;
          else begin
            ph_r <= 1'b0;
            if ({1'b0, step_r[1:0]} < nv) wv_r[step_r[1:0]] <= prod_r[47:16];
            else wv_r[step_r[1:0]] <= '0;
            if (step_r[1:0] == 2'd3) state_r <= ST_PUSH;
            else step_r <= step_r + 3'd1;
          end
        end

        // newest sample waits in the holding register until the next one
        // shows up, so that last can be set on the final one
        ST_PUSH: begin
          if (!hold_v_r) begin
            hold_r   <= new_item;
            hold_v_r <= 1'b1;
            state_r  <= ST_NEXTK;
          end else if (out_free) begin
            out_r   <= hold_r;
            hold_r  <= new_item;
            state_r <= ST_NEXTK;
          end
        end

        ST_NEXTK: begin
          if (k_r < win_r[5]) begin
            k_r     <= k_r + CW'(1);
            state_r <= ST_ZPOS;
          end else begin
            state_r <= ST_NEXTJ;
          end
        end

        ST_NEXTJ: begin
          if (j_r < win_r[3]) begin
            j_r     <= j_r + CW'(1);
            state_r <= ST_YPOS;
          end else begin
            state_r <= ST_NEXTI;
          end
        end

        ST_NEXTI: begin
          if (i_r < win_r[1]) begin
            i_r     <= i_r + CW'(1);
            state_r <= ST_XPOS;
          end else begin
            state_r <= ST_FIN;
          end
        end

        ST_FIN: begin
          if (!hold_v_r) begin
            state_r <= ST_IDLE;
          end else if (out_free) begin
            out_r    <= fin_item;
            hold_v_r <= 1'b0;
            state_r  <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

endmodule

// ===== rtl/psv_checker.sv =====
module psv_checker
  import psv_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input out_item_t            out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // one point at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // deferred and overflow requests stand alone
  a_over_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.item_kind != KIND_SAMPLE |->
      out_data.last && out_data.weight == '0 && out_data.slice == '0)
    else $error("oversized window result malformed");

  // samples carry no window end
  a_sample_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.item_kind == KIND_SAMPLE |->
      out_data.col_end == '0 && out_data.row_end == '0)
    else $error("sample carries window end");

endmodule

bind point_splat_volume_sampler psv_checker u_psv_checker (.*);
